[rtl/core/crdg_pkg.sv]
package crdg_pkg;

    // Datapath sizing
    localparam int MAX_DIM_BITS = 12;
    localparam int COEF_BITS    = 16;
    localparam int PIX_W        = 12;
    localparam int DIM_FIELD_W  = 13;
    localparam int SIZE_W       = MAX_DIM_BITS + 1;
    localparam int DIVR_W       = SIZE_W + 1;
    localparam int DIVD_W       = PIX_W + 1 + COEF_BITS + 2;
    localparam int QUO_W        = DIVD_W - 1;
    localparam int CRD_W        = QUO_W + 1;
    localparam int MAT_W        = 16;
    localparam int PROD_W       = MAT_W + CRD_W;
    localparam int T_W          = PROD_W + 2;
    localparam int MAG_W        = T_W;
    localparam int NORM_SHIFTS  = 6;
    localparam int UNIT_W       = 30;
    localparam int SQ_W         = 2 * UNIT_W;
    localparam int SUM_W        = SQ_W + 2;
    localparam int LEN_W        = SUM_W / 2;
    localparam int NFRAC        = 15;
    localparam int NDIV_STEPS   = NFRAC + 1;
    localparam int N_W          = 16;
    localparam int RAY_W        = 16;
    localparam int RFRAC        = 14;
    localparam int RPROD_W      = MAT_W + N_W;
    localparam int RSUM_W       = RPROD_W + 2;

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;
    localparam int PROJ_ROW_W = 64;
    localparam int ROT_ROW_W  = 48;

    localparam logic [CFG_ADDR_W-1:0] REG_VIEWPORT = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PROJ_X   = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PROJ_Y   = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PROJ_Z   = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PROJ_W   = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_X    = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_Y    = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_Z    = 4'd7;

    localparam logic [25:0]           RST_VIEWPORT = 26'd5899520;
    localparam logic [PROJ_ROW_W-1:0] RST_PROJ_X   = 64'd2048;
    localparam logic [PROJ_ROW_W-1:0] RST_PROJ_Y   = 64'd134217728;
    localparam logic [PROJ_ROW_W-1:0] RST_PROJ_Z   = 64'd8796093022208;
    localparam logic [PROJ_ROW_W-1:0] RST_PROJ_W   = 64'd576460752303423488;
    localparam logic [ROT_ROW_W-1:0]  RST_ROT_X    = 48'd16384;
    localparam logic [ROT_ROW_W-1:0]  RST_ROT_Y    = 48'd1073741824;
    localparam logic [ROT_ROW_W-1:0]  RST_ROT_Z    = 48'd70368744177664;

    typedef logic [3:0][PROJ_ROW_W-1:0] t_proj;
    typedef logic [2:0][ROT_ROW_W-1:0]  t_rot;

    typedef struct packed {
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
    } t_coord;

    typedef struct packed {
        logic [2:0][UNIT_W-1:0] a;
        logic [2:0]             neg;
        logic                   degen;
    } t_dir;

    typedef struct packed {
        logic [2:0][N_W-1:0] n;
        logic                degen;
    } t_unit;

    typedef struct packed {
        logic signed [RAY_W-1:0] x;
        logic signed [RAY_W-1:0] y;
        logic signed [RAY_W-1:0] z;
        logic                    degen;
    } t_ray;

    // Pick one signed 16-bit matrix entry out of a packed row
    function automatic logic signed [MAT_W-1:0] mat_entry(logic [PROJ_ROW_W-1:0] row,
                                                          int col);
        return row[col*MAT_W +: MAT_W];
    endfunction

    // Clamp a viewport dimension to 1 .. 2^MAX_DIM_BITS
    function automatic logic [SIZE_W-1:0] clamp_dim(logic [DIM_FIELD_W-1:0] s);
        logic [SIZE_W-1:0] res;
        if (s == '0) begin
            res = SIZE_W'(1);
        end else if (32'(s) > (32'd1 << MAX_DIM_BITS)) begin
            res = SIZE_W'(1 << MAX_DIM_BITS);
        end else begin
            res = SIZE_W'(s);
        end
        return res;
    endfunction

endpackage

[rtl/core/crdg_if.sv]
interface crdg_in_if;
    logic                            valid;
    logic                            ready;
    logic [crdg_pkg::PIX_W-1:0]      pixel_col;
    logic [crdg_pkg::PIX_W-1:0]      pixel_row;

    modport source (output valid, pixel_col, pixel_row, input ready);
    modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface crdg_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [crdg_pkg::RAY_W-1:0] ray_x;
    logic signed [crdg_pkg::RAY_W-1:0] ray_y;
    logic signed [crdg_pkg::RAY_W-1:0] ray_z;
    logic                            degenerate;

    modport source (output valid, ray_x, ray_y, ray_z, degenerate, input ready);
    modport sink   (input valid, ray_x, ray_y, ray_z, degenerate, output ready);
endinterface

[rtl/core/crdg_ndc.sv]
// Pixel to normalized device coordinate: one restoring quotient bit per stage
module crdg_ndc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [crdg_pkg::PIX_W-1:0]    i_col,
    input  logic [crdg_pkg::PIX_W-1:0]    i_row,
    input  logic [crdg_pkg::SIZE_W-1:0]   i_width,
    input  logic [crdg_pkg::SIZE_W-1:0]   i_height,
    output logic                          o_valid,
    output crdg_pkg::t_coord              o_crd
);
    localparam int QW  = crdg_pkg::QUO_W;
    localparam int DW  = crdg_pkg::DIVD_W;
    localparam int VW  = crdg_pkg::DIVR_W;
    localparam int TRW = VW + QW;

    logic                      r_vld [0:QW];
    logic [1:0][DW-1:0]        r_rem [0:QW];
    logic [1:0][QW-1:0]        r_quo [0:QW];
    logic [1:0][VW-1:0]        r_dvs [0:QW];
    logic                      r_out_vld;
    crdg_pkg::t_coord          r_crd;

    // Load dividend (2p+1)<<(C+1) + size and divisor 2*size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0][0] <= (DW'({i_col, 1'b1}) << (crdg_pkg::COEF_BITS + 1)) + DW'(i_width);
            r_rem[0][1] <= (DW'({i_row, 1'b1}) << (crdg_pkg::COEF_BITS + 1)) + DW'(i_height);
            r_dvs[0][0] <= {i_width, 1'b0};
            r_dvs[0][1] <= {i_height, 1'b0};
            r_quo[0]    <= '0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        localparam int SH = QW - k;
        logic [1:0][DW-1:0] n_rem;
        logic [1:0][QW-1:0] n_quo;

        // Try to subtract the shifted divisor on both axes
        always_comb begin
            logic [TRW-1:0] trial;
            for (int ax = 0; ax < 2; ax++) begin
                trial     = TRW'(r_dvs[k-1][ax]) << SH;
                n_rem[ax] = r_rem[k-1][ax];
                n_quo[ax] = r_quo[k-1][ax];
                if (TRW'(r_rem[k-1][ax]) >= trial) begin
                    n_rem[ax]     = r_rem[k-1][ax] - trial[DW-1:0];
                    n_quo[ax][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_dvs[k] <= r_dvs[k-1];
            end
        end
    end

    // Remove the offset of one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_crd.cx <= $signed(crdg_pkg::CRD_W'(r_quo[QW][0])
                        - crdg_pkg::CRD_W'(1 << crdg_pkg::COEF_BITS));
            r_crd.cy <= $signed(crdg_pkg::CRD_W'(r_quo[QW][1])
                        - crdg_pkg::CRD_W'(1 << crdg_pkg::COEF_BITS));
        end
    end

    assign o_valid = r_out_vld;
    assign o_crd   = r_crd;

endmodule

[rtl/core/crdg_proj.sv]
// Inverse projection, magnitudes and common normalizing shift
module crdg_proj (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  crdg_pkg::t_coord   i_crd,
    input  crdg_pkg::t_proj    i_proj,
    output logic               o_valid,
    output crdg_pkg::t_dir     o_dir
);
    localparam int PW = crdg_pkg::PROD_W;
    localparam int TW = crdg_pkg::T_W;
    localparam int MW = crdg_pkg::MAG_W;
    localparam int NS = crdg_pkg::NORM_SHIFTS;
    localparam int UW = crdg_pkg::UNIT_W;

    logic                         r_vld1, r_vld2, r_vld3;
    logic signed [PW-1:0]         r_p0 [0:3];
    logic signed [PW-1:0]         r_p1 [0:3];
    logic signed [crdg_pkg::MAT_W:0] r_k [0:3];
    logic signed [TW-1:0]         r_t [0:3];
    logic [2:0][MW-1:0]           r_a3;
    logic [2:0]                   r_neg3;
    logic                         r_wz3;
    logic [2:0][MW-1:0]           r_x [0:NS];
    logic [MW-1:0]                r_m [0:NS];
    logic [2:0]                   r_neg [0:NS];
    logic                         r_dg [0:NS];
    logic                         r_vn [0:NS];

    // Multiply the point (cx, cy, 1, 1) by each row
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r_p0[r] <= crdg_pkg::mat_entry(i_proj[r], 0) * i_crd.cx;
                r_p1[r] <= crdg_pkg::mat_entry(i_proj[r], 1) * i_crd.cy;
                r_k[r]  <= (crdg_pkg::MAT_W+1)'(crdg_pkg::mat_entry(i_proj[r], 2))
                         + (crdg_pkg::MAT_W+1)'(crdg_pkg::mat_entry(i_proj[r], 3));
            end
        end
    end

    // Sum the row terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r_t[r] <= TW'(r_p0[r]) + TW'(r_p1[r]) + (TW'(r_k[r]) <<< crdg_pkg::COEF_BITS);
            end
        end
    end

    // Take magnitudes and signs relative to w
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_a3[r]   <= r_t[r][TW-1] ? MW'(-r_t[r]) : MW'(r_t[r]);
                r_neg3[r] <= r_t[r][TW-1] ^ r_t[3][TW-1];
            end
            r_wz3 <= (r_t[3] == '0);
        end
    end

    // Find the largest magnitude
    always_ff @(posedge i_clk) begin
        logic [MW-1:0] m01;
        m01 = (r_a3[0] > r_a3[1]) ? r_a3[0] : r_a3[1];
        if (i_en) begin
            r_x[0]   <= r_a3;
            r_neg[0] <= r_neg3;
            r_m[0]   <= (m01 > r_a3[2]) ? m01 : r_a3[2];
            r_dg[0]  <= r_wz3 | ((r_a3[0] | r_a3[1] | r_a3[2]) == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1  <= 1'b0;
            r_vld2  <= 1'b0;
            r_vld3  <= 1'b0;
            r_vn[0] <= 1'b0;
        end else if (i_en) begin
            r_vld1  <= i_valid;
            r_vld2  <= r_vld1;
            r_vld3  <= r_vld2;
            r_vn[0] <= r_vld3;
        end
    end

    // Shift left by 32, 16, .. 1 while the top of the maximum is clear
    for (genvar j = 1; j <= NS; j++) begin : g_norm
        localparam int S = 1 << (NS - j);
        logic shift;
        assign shift = (r_m[j-1][MW-1 -: S] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vn[j] <= 1'b0;
            end else if (i_en) begin
                r_vn[j] <= r_vn[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int r = 0; r < 3; r++) begin
                    r_x[j][r] <= shift ? (r_x[j-1][r] << S) : r_x[j-1][r];
                end
                r_m[j]   <= shift ? (r_m[j-1] << S) : r_m[j-1];
                r_neg[j] <= r_neg[j-1];
                r_dg[j]  <= r_dg[j-1];
            end
        end
    end

    assign o_valid = r_vn[NS];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            o_dir.a[r] = r_x[NS][r][MW-1 -: UW];
        end
        o_dir.neg   = r_neg[NS];
        o_dir.degen = r_dg[NS];
    end

endmodule

[rtl/core/crdg_norm.sv]
// Unit vector: sum of squares, bit-serial square root, per-lane quotient
module crdg_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  crdg_pkg::t_dir     i_dir,
    output logic               o_valid,
    output crdg_pkg::t_unit    o_unit
);
    localparam int UW  = crdg_pkg::UNIT_W;
    localparam int SW  = crdg_pkg::SUM_W;
    localparam int LW  = crdg_pkg::LEN_W;
    localparam int ND  = crdg_pkg::NDIV_STEPS;
    localparam int RW  = UW + crdg_pkg::NFRAC;
    localparam int TRW = LW + ND - 1;
    localparam int NW  = crdg_pkg::N_W;

    logic                        r_vq1, r_vq2;
    logic [2:0][crdg_pkg::SQ_W-1:0] r_sq;
    crdg_pkg::t_dir              r_d1, r_d2;
    logic [SW-1:0]               r_sum;
    logic                        r_sv  [0:LW];
    logic [SW-1:0]               r_v   [0:LW];
    logic [SW-1:0]               r_res [0:LW];
    crdg_pkg::t_dir              r_sd  [0:LW];
    logic                        r_dv  [0:ND];
    logic [2:0][RW-1:0]          r_rem [0:ND];
    logic [2:0][ND-1:0]          r_q   [0:ND];
    logic [LW-1:0]               r_len [0:ND];
    logic [2:0]                  r_neg [0:ND];
    logic                        r_dg  [0:ND];
    logic                        r_ov;
    crdg_pkg::t_unit             r_unit;

    // Square each component, then add
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_sq[r] <= i_dir.a[r] * i_dir.a[r];
            end
            r_d1  <= i_dir;
            r_sum <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_d2  <= r_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq1 <= 1'b0;
            r_vq2 <= 1'b0;
        end else if (i_en) begin
            r_vq1 <= i_valid;
            r_vq2 <= r_vq1;
        end
    end

    assign r_sv[0]  = r_vq2;
    assign r_v[0]   = r_sum;
    assign r_res[0] = '0;
    assign r_sd[0]  = r_d2;

    // Square root, one result bit per stage
    for (genvar k = 1; k <= LW; k++) begin : g_sqrt
        localparam int I = LW - k;
        logic [SW-1:0] bitv, trial;
        logic          take;
        assign bitv  = SW'(1) << (2 * I);
        assign trial = r_res[k-1] + bitv;
        assign take  = (r_v[k-1] >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else if (i_en) begin
                r_sv[k] <= r_sv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k]   <= take ? (r_v[k-1] - trial) : r_v[k-1];
                r_res[k] <= take ? ((r_res[k-1] >> 1) + bitv) : (r_res[k-1] >> 1);
                r_sd[k]  <= r_sd[k-1];
            end
        end
    end

    // Load the quotient lanes with a << 15 over the length
    always_comb begin
        r_dv[0]  = r_sv[LW];
        r_len[0] = r_res[LW][LW-1:0];
        r_neg[0] = r_sd[LW].neg;
        r_dg[0]  = r_sd[LW].degen;
        r_q[0]   = '0;
        for (int r = 0; r < 3; r++) begin
            r_rem[0][r] = {r_sd[LW].a[r], {crdg_pkg::NFRAC{1'b0}}};
        end
    end

    for (genvar k = 1; k <= ND; k++) begin : g_div
        localparam int SH = ND - k;
        logic [2:0][RW-1:0] n_rem;
        logic [2:0][ND-1:0] n_q;

        always_comb begin
            logic [TRW-1:0] trial;
            trial = TRW'(r_len[k-1]) << SH;
            for (int r = 0; r < 3; r++) begin
                n_rem[r] = r_rem[k-1][r];
                n_q[r]   = r_q[k-1][r];
                if (TRW'(r_rem[k-1][r]) >= trial) begin
                    n_rem[r]    = r_rem[k-1][r] - trial[RW-1:0];
                    n_q[r][SH]  = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (i_en) begin
                r_dv[k] <= r_dv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
                r_len[k] <= r_len[k-1];
                r_neg[k] <= r_neg[k-1];
                r_dg[k]  <= r_dg[k-1];
            end
        end
    end

    // Round the half-step quotient and restore the sign
    always_ff @(posedge i_clk) begin
        logic [ND:0] mag;
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                mag = ((ND+1)'(r_q[ND][r]) + (ND+1)'(1)) >> 1;
                r_unit.n[r] <= r_neg[ND][r] ? NW'(-mag) : NW'(mag);
            end
            r_unit.degen <= r_dg[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_dv[ND];
        end
    end

    assign o_valid = r_ov;
    assign o_unit  = r_unit;

endmodule

[rtl/core/crdg_rot.sv]
// View rotation, rounding and saturation into the output register
module crdg_rot (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  crdg_pkg::t_unit    i_unit,
    input  crdg_pkg::t_rot     i_rot,
    output logic               o_valid,
    output crdg_pkg::t_ray     o_ray
);
    localparam int PW = crdg_pkg::RPROD_W;
    localparam int SW = crdg_pkg::RSUM_W;
    localparam int YW = crdg_pkg::RAY_W;

    logic                  r_v1, r_v2;
    logic signed [PW-1:0]  r_pr [0:2][0:2];
    logic                  r_dg1;
    logic signed [YW-1:0]  r_c [0:2];
    logic                  r_dg2;

    // Multiply each rotation entry by its unit component
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pr[r][c] <= crdg_pkg::mat_entry(crdg_pkg::PROJ_ROW_W'(i_rot[r]), c)
                                * $signed(i_unit.n[c]);
                end
            end
            r_dg1 <= i_unit.degen;
        end
    end

    // Add, round half up, saturate; force a zero ray when degenerate
    always_ff @(posedge i_clk) begin
        logic signed [SW-1:0]            s;
        logic signed [SW-crdg_pkg::RFRAC-1:0] q;
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                s = SW'(r_pr[r][0]) + SW'(r_pr[r][1]) + SW'(r_pr[r][2])
                  + SW'(1 << (crdg_pkg::RFRAC - 1));
                q = s[SW-1:crdg_pkg::RFRAC];
                if (r_dg1) begin
                    r_c[r] <= '0;
                end else if (q > (SW-crdg_pkg::RFRAC)'(32767)) begin
                    r_c[r] <= YW'(32767);
                end else if (q < -(SW-crdg_pkg::RFRAC)'(32768)) begin
                    r_c[r] <= -YW'(32768);
                end else begin
                    r_c[r] <= q[YW-1:0];
                end
            end
            r_dg2 <= r_dg1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid     = r_v2;
    assign o_ray.x     = r_c[0];
    assign o_ray.y     = r_c[1];
    assign o_ray.z     = r_c[2];
    assign o_ray.degen = r_dg2;

endmodule

[rtl/core/camera_ray_direction_generator.sv]
// Pinhole camera primary ray generator. Each accepted pixel (column, row) yields one
// unit world-space ray direction in signed Q2.14, plus a degenerate flag when w or the
// projected vector is zero. The block takes one pixel per clock while the result port
// does not stall and returns results in order; most of its depth is the chain of
// single-bit stages of the coordinate divider (30), the square root (31) and the
// normalizing divider (16). When the result port stalls, the whole pipeline holds.
// Write the viewport and matrices only while no request is in flight.
module camera_ray_direction_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [crdg_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [crdg_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    crdg_in_if.sink                             i_pix,
    crdg_out_if.source                          o_ray
);
    logic [25:0]          r_viewport;
    crdg_pkg::t_proj      r_proj;
    crdg_pkg::t_rot       r_rot;
    logic                 en;
    logic                 ndc_vld, proj_vld, norm_vld, rot_vld;
    crdg_pkg::t_coord     crd;
    crdg_pkg::t_dir       dir;
    crdg_pkg::t_unit      unit_v;
    crdg_pkg::t_ray       ray;
    logic [crdg_pkg::SIZE_W-1:0] width, height;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_viewport <= crdg_pkg::RST_VIEWPORT;
            r_proj[0]  <= crdg_pkg::RST_PROJ_X;
            r_proj[1]  <= crdg_pkg::RST_PROJ_Y;
            r_proj[2]  <= crdg_pkg::RST_PROJ_Z;
            r_proj[3]  <= crdg_pkg::RST_PROJ_W;
            r_rot[0]   <= crdg_pkg::RST_ROT_X;
            r_rot[1]   <= crdg_pkg::RST_ROT_Y;
            r_rot[2]   <= crdg_pkg::RST_ROT_Z;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                crdg_pkg::REG_VIEWPORT: r_viewport <= i_cfg_wdata[25:0];
                crdg_pkg::REG_PROJ_X:   r_proj[0]  <= i_cfg_wdata;
                crdg_pkg::REG_PROJ_Y:   r_proj[1]  <= i_cfg_wdata;
                crdg_pkg::REG_PROJ_Z:   r_proj[2]  <= i_cfg_wdata;
                crdg_pkg::REG_PROJ_W:   r_proj[3]  <= i_cfg_wdata;
                crdg_pkg::REG_ROT_X:    r_rot[0]   <= i_cfg_wdata[crdg_pkg::ROT_ROW_W-1:0];
                crdg_pkg::REG_ROT_Y:    r_rot[1]   <= i_cfg_wdata[crdg_pkg::ROT_ROW_W-1:0];
                crdg_pkg::REG_ROT_Z:    r_rot[2]   <= i_cfg_wdata[crdg_pkg::ROT_ROW_W-1:0];
                default: ;
            endcase
        end
    end

    assign width  = crdg_pkg::clamp_dim(r_viewport[12:0]);
    assign height = crdg_pkg::clamp_dim(r_viewport[25:13]);

    // Advance every stage unless a finished ray waits
    assign en          = !rot_vld || o_ray.ready;
    assign i_pix.ready = en;

    crdg_ndc u_ndc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_pix.valid),
        .i_col    (i_pix.pixel_col),
        .i_row    (i_pix.pixel_row),
        .i_width  (width),
        .i_height (height),
        .o_valid  (ndc_vld),
        .o_crd    (crd)
    );

    crdg_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ndc_vld),
        .i_crd   (crd),
        .i_proj  (r_proj),
        .o_valid (proj_vld),
        .o_dir   (dir)
    );

    crdg_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (proj_vld),
        .i_dir   (dir),
        .o_valid (norm_vld),
        .o_unit  (unit_v)
    );

    crdg_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (norm_vld),
        .i_unit  (unit_v),
        .i_rot   (r_rot),
        .o_valid (rot_vld),
        .o_ray   (ray)
    );

    assign o_ray.valid      = rot_vld;
    assign o_ray.ray_x      = ray.x;
    assign o_ray.ray_y      = ray.y;
    assign o_ray.ray_z      = ray.z;
    assign o_ray.degenerate = ray.degen;

endmodule

[rtl/core/crdg_checker.sv]
module crdg_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_ready,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic signed [crdg_pkg::RAY_W-1:0] i_ray_x,
    input  logic signed [crdg_pkg::RAY_W-1:0] i_ray_y,
    input  logic signed [crdg_pkg::RAY_W-1:0] i_ray_z,
    input  logic                             i_degenerate
);
    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Keep a stalled payload stable
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_ray_x) && $stable(i_ray_y)
        && $stable(i_ray_z) && $stable(i_degenerate))
        else $error("stalled result changed");

    // Accept requests whenever the result slot can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not track output slot");

    // Degenerate rays are zero
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |-> i_ray_x == 0 && i_ray_y == 0 && i_ray_z == 0)
        else $error("degenerate ray not zero");

endmodule

bind camera_ray_direction_generator crdg_checker u_crdg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_ray.valid),
    .i_out_ready  (o_ray.ready),
    .i_ray_x      (o_ray.ray_x),
    .i_ray_y      (o_ray.ray_y),
    .i_ray_z      (o_ray.ray_z),
    .i_degenerate (o_ray.degenerate)
);
